FILE: sv/pidpwm_pkg.sv
// Shared types and constants for the PID-to-PWM duty block.
// Used by the register file, controller, datapath and top level.
// No dependencies.
package pidpwm_pkg;

    // Register indexes on the configuration port (paddr[3:2])
    typedef enum logic [1:0] {
        REG_KP = 2'd0,
        REG_KI = 2'd1,
        REG_KD = 2'd2
    } reg_idx_t;

    // Gains, unsigned Q4.12
    typedef struct packed {
        logic [15:0] kp;
        logic [15:0] ki;
        logic [15:0] kd;
    } gains_t;

    localparam logic [15:0] KP_RESET = 16'd410;
    localparam logic [15:0] KI_RESET = 16'd532;
    localparam logic [15:0] KD_RESET = 16'd410;

    // Datapath step codes, one per state of the tick sequence
    typedef enum logic [3:0] {
        STEP_NONE,
        STEP_MUL_I,
        STEP_MUL_P,
        STEP_MUL_D,
        STEP_SUM,
        STEP_ROUND,
        STEP_SCALE,
        STEP_RECIP,
        STEP_EMIT
    } step_t;

    typedef struct packed {
        logic  load;
        step_t step;
    } dp_cmd_t;

    typedef struct packed {
        logic out_free;
    } dp_status_t;

    // Q.20 sum to Q8.8: round half up, then drop 12 bits
    localparam int         FRAC_SHIFT = 12;
    localparam logic [35:0] ROUND_BIAS = 36'd2048;

    // duty = floor(c * range / 25600) = floor(((c * range) >> 10) / 25)
    localparam int          PCT_SHIFT   = 10;
    localparam int          PCT_DIV     = 25;
    localparam int          RECIP_SHIFT = 26;
    localparam int          RECIP_W     = 22;
    localparam logic [21:0] RECIP_MULT  = 22'd2684354;  // floor(2^26 / 25)

endpackage

FILE: sv/pidpwm_regs.sv
// Configuration register file: three gain registers on an APB-style port.
// Depends on pidpwm_pkg.
module pidpwm_regs
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [3:0]            paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output pidpwm_pkg::gains_t    gains
);
    import pidpwm_pkg::*;

    gains_t   gains_reg;
    gains_t   gains_next;
    reg_idx_t idx;
    logic     wr_en;

    assign idx    = reg_idx_t'(paddr[3:2]);
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign gains  = gains_reg;

    // Write decode; an unused index is ignored
    always_comb
    begin
        gains_next = gains_reg;
        if (wr_en)
        begin
            unique case (idx)
                REG_KP:  gains_next.kp = pwdata[15:0];
                REG_KI:  gains_next.ki = pwdata[15:0];
                REG_KD:  gains_next.kd = pwdata[15:0];
                default: gains_next = gains_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gains_reg.kp <= KP_RESET;
            gains_reg.ki <= KI_RESET;
            gains_reg.kd <= KD_RESET;
        end
        else
        begin
            gains_reg <= gains_next;
        end
    end

    // Read-back mux
    always_comb
    begin
        unique case (idx)
            REG_KP:  prdata = {16'd0, gains_reg.kp};
            REG_KI:  prdata = {16'd0, gains_reg.ki};
            REG_KD:  prdata = {16'd0, gains_reg.kd};
            default: prdata = 32'd0;
        endcase
    end

endmodule

FILE: sv/pidpwm_ctrl.sv
// Tick sequencer: walks the datapath through one control tick per request.
// Depends on pidpwm_pkg.
module pidpwm_ctrl
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  pidpwm_pkg::dp_status_t  status,
    output pidpwm_pkg::dp_cmd_t     cmd
);
    import pidpwm_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_I,
        ST_MUL_P,
        ST_MUL_D,
        ST_SUM,
        ST_ROUND,
        ST_SCALE,
        ST_RECIP,
        ST_EMIT
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ready_reg;
    logic   ready_next;

    assign in_ready = ready_reg;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        ready_next = ready_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_MUL_I;
                    ready_next = 1'b0;
                end
            end
            ST_MUL_I: state_next = ST_MUL_P;
            ST_MUL_P: state_next = ST_MUL_D;
            ST_MUL_D: state_next = ST_SUM;
            ST_SUM:   state_next = ST_ROUND;
            ST_ROUND: state_next = ST_SCALE;
            ST_SCALE: state_next = ST_RECIP;
            ST_RECIP: state_next = ST_EMIT;
            ST_EMIT:
            begin
                // hold until the output register can take the result
                if (status.out_free)
                begin
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end
        else
        begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    // Command decode
    always_comb
    begin
        cmd.load = in_valid && ready_reg;
        unique case (state_reg)
            ST_MUL_I: cmd.step = STEP_MUL_I;
            ST_MUL_P: cmd.step = STEP_MUL_P;
            ST_MUL_D: cmd.step = STEP_MUL_D;
            ST_SUM:   cmd.step = STEP_SUM;
            ST_ROUND: cmd.step = STEP_ROUND;
            ST_SCALE: cmd.step = STEP_SCALE;
            ST_RECIP: cmd.step = STEP_RECIP;
            ST_EMIT:  cmd.step = status.out_free ? STEP_EMIT : STEP_NONE;
            default:  cmd.step = STEP_NONE;
        endcase
    end

endmodule

FILE: sv/pidpwm_dp.sv
// PID datapath: error, shared gain multiplier, saturating integral,
// rounding, duty scaling by reciprocal multiply, and the result register.
// Depends on pidpwm_pkg.
module pidpwm_dp
#(
    parameter int DUTY_RANGE = 256
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  pidpwm_pkg::gains_t      gains,
    input  pidpwm_pkg::dp_cmd_t     cmd,
    output pidpwm_pkg::dp_status_t  status,
    input  logic [15:0]             target_level,
    input  logic [15:0]             measured_level,
    output logic [15:0]             control_value,
    output logic [8:0]              duty_count,
    output logic                    clamped,
    output logic                    out_valid,
    input  logic                    out_ready
);
    import pidpwm_pkg::*;

    localparam int DW = $clog2(DUTY_RANGE + 1);   // bits of the range value
    localparam int XW = 15 + DW;                  // control * range
    localparam int YW = XW - PCT_SHIFT;           // after the power-of-two part
    localparam int PW = YW + RECIP_W;             // reciprocal product
    localparam int QW = PW - RECIP_SHIFT;         // quotient estimate
    localparam logic [31:0] RANGE32 = 32'(DUTY_RANGE);

    logic signed [16:0] err_reg,   err_next;
    logic signed [17:0] derr_reg,  derr_next;
    logic signed [16:0] prev_reg,  prev_next;
    logic signed [31:0] integ_reg, integ_next;
    logic signed [34:0] prod_reg,  prod_next;
    logic signed [35:0] acc_reg,   acc_next;
    logic signed [15:0] c_reg,     c_next;
    logic [XW-1:0]      x_reg,     x_next;
    logic [PW-1:0]      rprod_reg, rprod_next;
    logic [15:0]        outc_reg,  outc_next;
    logic [8:0]         duty_reg,  duty_next;
    logic               clamp_reg, clamp_next;
    logic               valid_reg, valid_next;

    logic signed [16:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [35:0] isum;
    logic signed [35:0] rsum;
    logic signed [23:0] rshift;
    logic [14:0]        cpos;
    logic [YW-1:0]      yval;
    logic [QW-1:0]      q0;
    logic [YW-1:0]      rem;
    logic [QW-1:0]      quot;
    logic [31:0]        duty_full;
    logic               duty_clamp;

    assign status.out_free = !valid_reg || out_ready;
    assign control_value   = outc_reg;
    assign duty_count      = duty_reg;
    assign clamped         = clamp_reg;
    assign out_valid       = valid_reg;

    // Error and error difference at request time
    always_comb
    begin
        err_next  = $signed({target_level[15], target_level})
                  - $signed({measured_level[15], measured_level});
        derr_next = $signed({err_next[16], err_next}) - $signed({prev_reg[16], prev_reg});
        prev_next = cmd.load ? err_next : prev_reg;
    end

    // Shared gain multiplier operand select
    always_comb
    begin
        unique case (cmd.step)
            STEP_MUL_I:
            begin
                mul_a = $signed({1'b0, gains.ki});
                mul_b = 18'(err_reg);
            end
            STEP_MUL_P:
            begin
                mul_a = $signed({1'b0, gains.kp});
                mul_b = 18'(err_reg);
            end
            STEP_MUL_D:
            begin
                mul_a = $signed({1'b0, gains.kd});
                mul_b = derr_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    assign prod_next = 35'(mul_a) * 35'(mul_b);

    // Saturating integral update
    always_comb
    begin
        isum = 36'(integ_reg) + 36'(prod_reg);
        if ((isum[35:31] == 5'b00000) || (isum[35:31] == 5'b11111))
            integ_next = isum[31:0];
        else if (isum[35])
            integ_next = 32'sh8000_0000;
        else
            integ_next = 32'sh7FFF_FFFF;
    end

    // Round half up to Q8.8 and saturate
    always_comb
    begin
        rsum   = acc_reg + $signed(ROUND_BIAS);
        rshift = rsum[35:FRAC_SHIFT];
        if ((rshift[23:15] == 9'h000) || (rshift[23:15] == 9'h1FF))
            c_next = rshift[15:0];
        else if (rshift[23])
            c_next = 16'sh8000;
        else
            c_next = 16'sh7FFF;
    end

    // Duty: scale, reciprocal divide by 25, one correction step, clamp
    always_comb
    begin
        cpos       = c_reg[15] ? 15'd0 : c_reg[14:0];
        x_next     = XW'(cpos) * XW'(DUTY_RANGE);
        yval       = x_reg[XW-1:PCT_SHIFT];
        rprod_next = PW'(yval) * PW'(RECIP_MULT);
        q0         = rprod_reg[PW-1:RECIP_SHIFT];
        rem        = yval - YW'(q0) * YW'(PCT_DIV);
        quot       = (rem >= YW'(PCT_DIV)) ? q0 + QW'(1) : q0;
        if (c_reg[15])
        begin
            duty_full  = 32'd0;
            duty_clamp = 1'b1;
        end
        else if (32'(quot) > RANGE32)
        begin
            duty_full  = RANGE32;
            duty_clamp = 1'b1;
        end
        else
        begin
            duty_full  = 32'(quot);
            duty_clamp = 1'b0;
        end
    end

    // Result register
    always_comb
    begin
        outc_next  = outc_reg;
        duty_next  = duty_reg;
        clamp_next = clamp_reg;
        valid_next = out_ready ? 1'b0 : valid_reg;
        if (cmd.step == STEP_EMIT)
        begin
            outc_next  = c_reg;
            duty_next  = duty_full[8:0];
            clamp_next = duty_clamp;
            valid_next = 1'b1;
        end
    end

    // Working registers, loaded by step
    always_comb
    begin
        acc_next = acc_reg;
        unique case (cmd.step)
            STEP_MUL_D: acc_next = 36'(prod_reg) + 36'(integ_reg);
            STEP_SUM:   acc_next = acc_reg + 36'(prod_reg);
            default:    acc_next = acc_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            err_reg  <= err_next;
            derr_reg <= derr_next;
        end
        if ((cmd.step == STEP_MUL_I) || (cmd.step == STEP_MUL_P) ||
            (cmd.step == STEP_MUL_D))
            prod_reg <= prod_next;
        acc_reg <= acc_next;
        if (cmd.step == STEP_ROUND)
            c_reg <= c_next;
        if (cmd.step == STEP_SCALE)
            x_reg <= x_next;
        if (cmd.step == STEP_RECIP)
            rprod_reg <= rprod_next;
        outc_reg  <= outc_next;
        duty_reg  <= duty_next;
        clamp_reg <= clamp_next;
    end

    // Controller state of the loop: error history, integral, result valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_reg  <= '0;
            integ_reg <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            prev_reg  <= prev_next;
            if (cmd.step == STEP_MUL_P)
                integ_reg <= integ_next;
            valid_reg <= valid_next;
        end
    end

endmodule

FILE: sv/pid_to_pwm_duty.sv
// Positional PID controller producing a PWM duty word, one result per tick.
// Each accepted request runs an 8-step sequence through one shared gain multiplier, the
// last step loading the result register once the output register is free.
// A new request is taken once the last result is in the output register.
// Reset clears integral, previous error and output valid.
// Gains reset to Kp=410, Ki=532, Kd=410 (Q4.12). Depends on pidpwm_pkg and submodules.
module pid_to_pwm_duty
#(
    parameter int DUTY_RANGE = 256
)
(
    input  logic        clk,
    input  logic        rst_n,
    // configuration port
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    // request stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [15:0] target_level, [31:16] measured_level
    // result stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [15:0] control_value, [24:16] duty_count, rest 0
    output logic        m_tuser    // [0] clamped
);
    import pidpwm_pkg::*;

    gains_t     gains;
    dp_cmd_t    cmd;
    dp_status_t status;
    logic [15:0] control_value;
    logic [8:0]  duty_count;

    pidpwm_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .gains   (gains)
    );

    pidpwm_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pidpwm_dp #(.DUTY_RANGE(DUTY_RANGE)) u_dp
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .gains          (gains),
        .cmd            (cmd),
        .status         (status),
        .target_level   (s_tdata[15:0]),
        .measured_level (s_tdata[31:16]),
        .control_value  (control_value),
        .duty_count     (duty_count),
        .clamped        (m_tuser),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready)
    );

    assign m_tdata = {7'd0, duty_count, control_value};

endmodule
